@@ src/est_pkg.sv @@
// Shared types, constants and the CORDIC arctangent table for the
// Euler rotation/scale/translation matrix block. No dependencies.
`timescale 1ns / 1ps
package est_pkg;

  localparam int unsigned SINCOS_BITS_DEF = 16;
  localparam int unsigned ANG_W   = 16;
  localparam int unsigned SCL_W   = 16;
  localparam int unsigned OFS_W   = 32;
  localparam int unsigned ENT_W   = 25;
  localparam int unsigned CW      = 34;   // CORDIC datapath width
  localparam int unsigned RED_W   = 15;   // reduced angle, [0, 23040)
  localparam int unsigned TABLE_LEN   = 25;
  localparam int unsigned CORDIC_FRAC = 30;
  localparam int signed   FULL_TURN   = 23040;
  localparam longint unsigned GAIN_INV = 64'd652032874;
  // phase = red*2^32/23040 rounded = red*PH_MUL + (23*red + 22)/45
  localparam longint unsigned PH_MUL  = 64'd186413;
  localparam longint unsigned REC_MUL = 64'd1491309;   // ceil(2^26/45)
  localparam int unsigned     REC_SH  = 26;
  localparam int signed   ENT_MAX = 16777215;
  localparam int signed   ENT_MIN = -16777216;

  typedef logic signed [CW-1:0] cw_t;

  typedef struct packed {
    cw_t        x;
    cw_t        y;
    cw_t        z;
    logic [1:0] quad;
  } rot_t;

  typedef struct packed {
    logic signed [SCL_W-1:0] scale_x;
    logic signed [SCL_W-1:0] scale_y;
    logic signed [SCL_W-1:0] scale_z;
    logic signed [OFS_W-1:0] offset_x;
    logic signed [OFS_W-1:0] offset_y;
    logic signed [OFS_W-1:0] offset_z;
  } side_t;

  // atan(2^-i) as a fraction of a full turn, times 2^32
  function automatic cw_t atan_turn(input int unsigned idx);
    cw_t v;
    case (idx)
      0:  v = CW'(536870912);
      1:  v = CW'(316933406);
      2:  v = CW'(167458907);
      3:  v = CW'(85004756);
      4:  v = CW'(42667331);
      5:  v = CW'(21354465);
      6:  v = CW'(10679838);
      7:  v = CW'(5340245);
      8:  v = CW'(2670163);
      9:  v = CW'(1335087);
      10: v = CW'(667544);
      11: v = CW'(333772);
      12: v = CW'(166886);
      13: v = CW'(83443);
      14: v = CW'(41722);
      15: v = CW'(20861);
      16: v = CW'(10430);
      17: v = CW'(5215);
      18: v = CW'(2608);
      19: v = CW'(1304);
      20: v = CW'(652);
      21: v = CW'(326);
      22: v = CW'(163);
      23: v = CW'(81);
      24: v = CW'(41);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ src/est_phase.sv @@
// Angle front end: modulo-360 reduction, scaling to a 32-bit binary angle,
// quadrant split and CORDIC seed. Three stages. Depends on est_pkg.
`timescale 1ns / 1ps
module est_phase (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            vld_i,
  output logic                            rdy_o,
  input  logic signed [est_pkg::ANG_W-1:0] ang_i [3],
  input  est_pkg::side_t                  side_i,
  output logic                            vld_o,
  input  logic                            rdy_i,
  output est_pkg::rot_t [2:0]             rot_o,
  output est_pkg::side_t                  side_o
);
  import est_pkg::*;

  localparam int unsigned M1_W = 33;
  localparam int unsigned N_W  = 20;
  localparam int unsigned M2_W = 41;

  logic [2:0] vld_r;
  logic [2:0] rdy;

  logic [RED_W-1:0] red_nxt [3];
  logic [RED_W-1:0] red_r [3];
  logic [M1_W-1:0]  m1_nxt [3];
  logic [M1_W-1:0]  m1_r [3];
  logic [M2_W-1:0]  m2_nxt [3];
  logic [M2_W-1:0]  m2_r [3];
  rot_t [2:0]       rot_nxt;
  rot_t [2:0]       rot_r;
  side_t            side_a_r, side_b_r, side_c_r;

  assign rdy[2] = !vld_r[2] || rdy_i;
  assign rdy[1] = !vld_r[1] || rdy[2];
  assign rdy[0] = !vld_r[0] || rdy[1];
  assign rdy_o  = rdy[0];

  always_comb begin
    logic signed [17:0] a0, s1, s2, s3;
    logic [N_W-1:0]     n;
    logic [31:0]        ph;
    for (int k = 0; k < 3; k++) begin
      a0 = 18'(ang_i[k]);
      s1 = a0 + 18'sd23040;
      s2 = a0 + 18'sd46080;
      s3 = a0 - 18'sd23040;
      if (a0 < -18'sd23040)     red_nxt[k] = s2[RED_W-1:0];
      else if (a0 < 18'sd0)     red_nxt[k] = s1[RED_W-1:0];
      else if (a0 >= 18'sd23040) red_nxt[k] = s3[RED_W-1:0];
      else                      red_nxt[k] = a0[RED_W-1:0];

      m1_nxt[k] = M1_W'(red_r[k]) * M1_W'(PH_MUL);
      n         = N_W'(red_r[k]) * N_W'(23) + N_W'(22);
      m2_nxt[k] = M2_W'(n) * M2_W'(REC_MUL);

      ph = m1_r[k][31:0] + 32'(m2_r[k][M2_W-1:REC_SH]);
      rot_nxt[k].x    = cw_t'(GAIN_INV);
      rot_nxt[k].y    = '0;
      rot_nxt[k].z    = cw_t'(ph[29:0]);
      rot_nxt[k].quad = ph[31:30];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= vld_i;
      if (rdy[1]) vld_r[1] <= vld_r[0];
      if (rdy[2]) vld_r[2] <= vld_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      red_r    <= red_nxt;
      side_a_r <= side_i;
    end
    if (rdy[1]) begin
      m1_r     <= m1_nxt;
      m2_r     <= m2_nxt;
      side_b_r <= side_a_r;
    end
    if (rdy[2]) begin
      rot_r    <= rot_nxt;
      side_c_r <= side_b_r;
    end
  end

  assign vld_o  = vld_r[2];
  assign rot_o  = rot_r;
  assign side_o = side_c_r;

endmodule

@@ src/est_cordic_cell.sv @@
// One CORDIC rotation step for all three axes, registered.
// IDX selects the shift and the arctangent constant. Depends on est_pkg.
`timescale 1ns / 1ps
module est_cordic_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                vld_i,
  output logic                rdy_o,
  input  est_pkg::rot_t [2:0] rot_i,
  input  est_pkg::side_t      side_i,
  output logic                vld_o,
  input  logic                rdy_i,
  output est_pkg::rot_t [2:0] rot_o,
  output est_pkg::side_t      side_o
);
  import est_pkg::*;

  localparam cw_t ATAN = atan_turn(IDX);

  logic       vld_r;
  rot_t [2:0] rot_nxt;
  rot_t [2:0] rot_r;
  side_t      side_r;
  cw_t        xs [3];
  cw_t        ys [3];
  cw_t        zs [3];

  assign rdy_o = !vld_r || rdy_i;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      xs[k] = rot_i[k].x;
      ys[k] = rot_i[k].y;
      zs[k] = rot_i[k].z;
      rot_nxt[k].quad = rot_i[k].quad;
      if (!zs[k][CW-1]) begin
        rot_nxt[k].x = xs[k] - (ys[k] >>> IDX);
        rot_nxt[k].y = ys[k] + (xs[k] >>> IDX);
        rot_nxt[k].z = zs[k] - ATAN;
      end else begin
        rot_nxt[k].x = xs[k] + (ys[k] >>> IDX);
        rot_nxt[k].y = ys[k] - (xs[k] >>> IDX);
        rot_nxt[k].z = zs[k] + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy_o) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o) begin
      rot_r  <= rot_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign rot_o  = rot_r;
  assign side_o = side_r;

endmodule

@@ src/est_mat.sv @@
// Matrix back end: sine/cosine rounding and quadrant fold, product chain,
// row sums, scale multiply, round and saturate. Six stages. Depends on est_pkg.
`timescale 1ns / 1ps
module est_mat #(
  parameter int unsigned SB = est_pkg::SINCOS_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             vld_i,
  output logic                             rdy_o,
  input  est_pkg::rot_t [2:0]              rot_i,
  input  est_pkg::side_t                   side_i,
  output logic                             vld_o,
  input  logic                             rdy_i,
  output logic signed [est_pkg::ENT_W-1:0] ent_o [9],
  output est_pkg::side_t                   side_o
);
  import est_pkg::*;

  localparam int unsigned TW = SB + 2;
  localparam int unsigned PW = 2 * TW;
  localparam int unsigned VW = TW + 1;
  localparam int unsigned MW = VW + SCL_W;
  localparam int unsigned SH = CORDIC_FRAC - SB;
  localparam cw_t RND_R   = cw_t'(1) <<< (SH - 1);
  localparam cw_t ONE     = cw_t'(1) <<< SB;
  localparam cw_t NEG_ONE = -ONE;
  localparam logic signed [PW-1:0] RND_F = PW'(1) <<< (SB - 1);
  localparam logic signed [MW-1:0] RND_O = MW'(1) <<< (SB - 9);
  localparam logic signed [MW-1:0] E_MAX = MW'(ENT_MAX);
  localparam logic signed [MW-1:0] E_MIN = MW'(ENT_MIN);

  function automatic logic signed [TW-1:0] fmul(input logic signed [TW-1:0] a,
                                                input logic signed [TW-1:0] b);
    logic signed [PW-1:0] p;
    p = a * b;
    p = p + RND_F;
    return TW'(p >>> SB);
  endfunction

  logic [5:0] vld_r;
  logic [5:0] rdy;
  side_t      side_r [6];

  // stage 0: cos/sin per axis (0 = x, 1 = y, 2 = z)
  logic signed [TW-1:0] c_nxt [3], s_nxt [3], c_r [3], s_r [3];
  // stage 1: pairwise products
  logic signed [TW-1:0] cycz_r, sxsy_r, cxsy_r, cxsz_r, sxsz_r, cysz_r;
  logic signed [TW-1:0] cxcz_r, sxcz_r, sxcy_r, cxcy_r, sy1_r, cz1_r, sz1_r;
  // stage 2: triple products, pairs passed on
  logic signed [TW-1:0] t1_r, t2_r, t3_r, t4_r;
  logic signed [TW-1:0] cycz2_r, cxsz2_r, sxsz2_r, cysz2_r, cxcz2_r, sxcz2_r;
  logic signed [TW-1:0] sxcy2_r, cxcy2_r, sy2_r;
  // stage 3..5
  logic signed [VW-1:0]    v_nxt [9], v_r [9];
  logic signed [MW-1:0]    p_nxt [9], p_r [9];
  logic signed [ENT_W-1:0] e_nxt [9], e_r [9];

  assign rdy[5] = !vld_r[5] || rdy_i;
  for (genvar g = 0; g < 5; g++) begin : g_rdy
    assign rdy[g] = !vld_r[g] || rdy[g+1];
  end
  assign rdy_o = rdy[0];

  always_comb begin
    cw_t xr, yr, xc, yc;
    logic signed [TW-1:0] c, s;
    logic signed [SCL_W-1:0] scl;
    logic signed [MW-1:0] rr;
    for (int k = 0; k < 3; k++) begin
      xr = (rot_i[k].x + RND_R) >>> SH;
      yr = (rot_i[k].y + RND_R) >>> SH;
      xc = (xr > ONE) ? ONE : ((xr < NEG_ONE) ? NEG_ONE : xr);
      yc = (yr > ONE) ? ONE : ((yr < NEG_ONE) ? NEG_ONE : yr);
      c  = TW'(xc);
      s  = TW'(yc);
      case (rot_i[k].quad)
        2'd0: begin c_nxt[k] = c;  s_nxt[k] = s;  end
        2'd1: begin c_nxt[k] = -s; s_nxt[k] = c;  end
        2'd2: begin c_nxt[k] = -c; s_nxt[k] = -s; end
        default: begin c_nxt[k] = s; s_nxt[k] = -c; end
      endcase
    end

    v_nxt[0] = VW'(cycz2_r);
    v_nxt[1] = VW'(t1_r) + VW'(cxsz2_r);
    v_nxt[2] = VW'(sxsz2_r) - VW'(t2_r);
    v_nxt[3] = -VW'(cysz2_r);
    v_nxt[4] = VW'(cxcz2_r) - VW'(t3_r);
    v_nxt[5] = VW'(t4_r) + VW'(sxcz2_r);
    v_nxt[6] = VW'(sy2_r);
    v_nxt[7] = -VW'(sxcy2_r);
    v_nxt[8] = VW'(cxcy2_r);

    for (int k = 0; k < 9; k++) begin
      if (k < 3)      scl = side_r[3].scale_x;
      else if (k < 6) scl = side_r[3].scale_y;
      else            scl = side_r[3].scale_z;
      p_nxt[k] = MW'(v_r[k]) * MW'(scl);
      rr = (p_r[k] + RND_O) >>> (SB - 8);
      if (rr > E_MAX)      e_nxt[k] = ENT_W'(E_MAX);
      else if (rr < E_MIN) e_nxt[k] = ENT_W'(E_MIN);
      else                 e_nxt[k] = ENT_W'(rr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) vld_r[0] <= vld_i;
      for (int k = 1; k < 6; k++) begin
        if (rdy[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      c_r <= c_nxt;
      s_r <= s_nxt;
      side_r[0] <= side_i;
    end
    if (rdy[1]) begin
      cycz_r <= fmul(c_r[1], c_r[2]);
      sxsy_r <= fmul(s_r[0], s_r[1]);
      cxsy_r <= fmul(c_r[0], s_r[1]);
      cxsz_r <= fmul(c_r[0], s_r[2]);
      sxsz_r <= fmul(s_r[0], s_r[2]);
      cysz_r <= fmul(c_r[1], s_r[2]);
      cxcz_r <= fmul(c_r[0], c_r[2]);
      sxcz_r <= fmul(s_r[0], c_r[2]);
      sxcy_r <= fmul(s_r[0], c_r[1]);
      cxcy_r <= fmul(c_r[0], c_r[1]);
      sy1_r  <= s_r[1];
      cz1_r  <= c_r[2];
      sz1_r  <= s_r[2];
      side_r[1] <= side_r[0];
    end
    if (rdy[2]) begin
      t1_r    <= fmul(sxsy_r, cz1_r);
      t2_r    <= fmul(cxsy_r, cz1_r);
      t3_r    <= fmul(sxsy_r, sz1_r);
      t4_r    <= fmul(cxsy_r, sz1_r);
      cycz2_r <= cycz_r;
      cxsz2_r <= cxsz_r;
      sxsz2_r <= sxsz_r;
      cysz2_r <= cysz_r;
      cxcz2_r <= cxcz_r;
      sxcz2_r <= sxcz_r;
      sxcy2_r <= sxcy_r;
      cxcy2_r <= cxcy_r;
      sy2_r   <= sy1_r;
      side_r[2] <= side_r[1];
    end
    if (rdy[3]) begin
      v_r <= v_nxt;
      side_r[3] <= side_r[2];
    end
    if (rdy[4]) begin
      p_r <= p_nxt;
      side_r[4] <= side_r[3];
    end
    if (rdy[5]) begin
      e_r <= e_nxt;
      side_r[5] <= side_r[4];
    end
  end

  assign vld_o  = vld_r[5];
  assign ent_o  = e_r;
  assign side_o = side_r[5];

endmodule

@@ src/euler_scale_transform_matrix.sv @@
// Top level of the Euler XYZ rotation / scale / translation matrix block.
// Instantiates est_phase, a row of est_cordic_cell and est_mat; uses est_pkg.
`timescale 1ns / 1ps
// Streaming transform setup: one transaction in, one transaction out. Each
// input (three angles in 1/64 degree, three Q8.8 scales, a Q16.16 position)
// yields the nine scaled rotation entries of R = Rx*Ry*Rz, Q8.16 saturated to
// 25 bits, plus the position unchanged. Throughput is one transaction per
// clock while out_stall is low. A transaction passes through angle reduction
// and phase scaling, one CORDIC cell per iteration, each rotating all three
// axes at once, then rounding, the product chain, row sums, the scale
// multiply and saturation into the output register. Every stage has its own
// valid bit and a stage advances whenever the one after it is free, so
// bubbles close up and in_stall only rises once every stage holds a
// transaction behind a stalled output. Reset clears the valid bits only.
module euler_scale_transform_matrix #(
  parameter int unsigned SINCOS_BITS = est_pkg::SINCOS_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [est_pkg::ANG_W-1:0]  in_angle_x,
  input  logic signed [est_pkg::ANG_W-1:0]  in_angle_y,
  input  logic signed [est_pkg::ANG_W-1:0]  in_angle_z,
  input  logic signed [est_pkg::SCL_W-1:0]  in_scale_x,
  input  logic signed [est_pkg::SCL_W-1:0]  in_scale_y,
  input  logic signed [est_pkg::SCL_W-1:0]  in_scale_z,
  input  logic signed [est_pkg::OFS_W-1:0]  in_offset_x,
  input  logic signed [est_pkg::OFS_W-1:0]  in_offset_y,
  input  logic signed [est_pkg::OFS_W-1:0]  in_offset_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [est_pkg::ENT_W-1:0]  out_m00,
  output logic signed [est_pkg::ENT_W-1:0]  out_m01,
  output logic signed [est_pkg::ENT_W-1:0]  out_m02,
  output logic signed [est_pkg::ENT_W-1:0]  out_m10,
  output logic signed [est_pkg::ENT_W-1:0]  out_m11,
  output logic signed [est_pkg::ENT_W-1:0]  out_m12,
  output logic signed [est_pkg::ENT_W-1:0]  out_m20,
  output logic signed [est_pkg::ENT_W-1:0]  out_m21,
  output logic signed [est_pkg::ENT_W-1:0]  out_m22,
  output logic signed [est_pkg::OFS_W-1:0]  out_tx,
  output logic signed [est_pkg::OFS_W-1:0]  out_ty,
  output logic signed [est_pkg::OFS_W-1:0]  out_tz
);
  import est_pkg::*;

  // CORDIC runs SINCOS_BITS+1 iterations, capped by the arctangent table
  localparam int unsigned NCELL =
    (SINCOS_BITS + 1 < TABLE_LEN) ? SINCOS_BITS + 1 : TABLE_LEN;

  logic signed [ANG_W-1:0] ang [3];
  side_t side_in;

  // chain wiring: index 0 is the front end's output, NCELL the last cell's
  logic       c_vld  [NCELL+1];
  logic       c_rdy  [NCELL+1];
  rot_t [2:0] c_rot  [NCELL+1];
  side_t      c_side [NCELL+1];

  logic        fe_rdy;
  logic        be_vld;
  logic signed [ENT_W-1:0] ent [9];
  side_t       side_out;

  assign ang[0] = in_angle_x;
  assign ang[1] = in_angle_y;
  assign ang[2] = in_angle_z;

  assign side_in.scale_x  = in_scale_x;
  assign side_in.scale_y  = in_scale_y;
  assign side_in.scale_z  = in_scale_z;
  assign side_in.offset_x = in_offset_x;
  assign side_in.offset_y = in_offset_y;
  assign side_in.offset_z = in_offset_z;

  est_phase u_phase (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (in_valid),
    .rdy_o  (fe_rdy),
    .ang_i  (ang),
    .side_i (side_in),
    .vld_o  (c_vld[0]),
    .rdy_i  (c_rdy[0]),
    .rot_o  (c_rot[0]),
    .side_o (c_side[0])
  );

  assign in_stall = !fe_rdy;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    est_cordic_cell #(.IDX(i)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (c_vld[i]),
      .rdy_o  (c_rdy[i]),
      .rot_i  (c_rot[i]),
      .side_i (c_side[i]),
      .vld_o  (c_vld[i+1]),
      .rdy_i  (c_rdy[i+1]),
      .rot_o  (c_rot[i+1]),
      .side_o (c_side[i+1])
    );
  end

  est_mat #(.SB(SINCOS_BITS)) u_mat (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (c_vld[NCELL]),
    .rdy_o  (c_rdy[NCELL]),
    .rot_i  (c_rot[NCELL]),
    .side_i (c_side[NCELL]),
    .vld_o  (be_vld),
    .rdy_i  (!out_stall),
    .ent_o  (ent),
    .side_o (side_out)
  );

  assign out_valid = be_vld;
  assign out_m00 = ent[0];
  assign out_m01 = ent[1];
  assign out_m02 = ent[2];
  assign out_m10 = ent[3];
  assign out_m11 = ent[4];
  assign out_m12 = ent[5];
  assign out_m20 = ent[6];
  assign out_m21 = ent[7];
  assign out_m22 = ent[8];
  assign out_tx  = side_out.offset_x;
  assign out_ty  = side_out.offset_y;
  assign out_tz  = side_out.offset_z;

endmodule

@@ src/est_chk.sv @@
// Port-level checker for euler_scale_transform_matrix, bound to the top.
// Depends on est_pkg for field widths.
`timescale 1ns / 1ps
module est_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [est_pkg::ENT_W-1:0] out_m00,
  input logic signed [est_pkg::OFS_W-1:0] out_tx
);
  import est_pkg::*;

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // an empty output register means every stage can advance
  a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output register empty");

  // a held transaction stays intact
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_m00) && $stable(out_tx))
    else $error("stalled output transaction changed");

endmodule

bind euler_scale_transform_matrix est_chk u_est_chk (.*);

@@ tb/euler_scale_transform_matrix_tb.sv @@
// Self-checking bench for euler_scale_transform_matrix: directed table plus
// random transactions, checked against a built-in fixed-point predictor.
// Depends on est_pkg and the block under test.
`timescale 1ns / 1ps
module euler_scale_transform_matrix_tb;
  import est_pkg::*;

  localparam int SCB = 16;            // sine/cosine fraction bits
  localparam int LATENCY = 26;
  localparam int N_RANDOM = 480;

  typedef struct packed {
    logic signed [15:0] ax, ay, az, sx, sy, sz;
    logic signed [31:0] ox, oy, oz;
  } xform_in_t;

  typedef struct packed {
    logic signed [24:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [31:0] tx, ty, tz;
  } xform_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  xform_in_t drv = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  xform_out_t got;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  euler_scale_transform_matrix u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_angle_x(drv.ax), .in_angle_y(drv.ay), .in_angle_z(drv.az),
    .in_scale_x(drv.sx), .in_scale_y(drv.sy), .in_scale_z(drv.sz),
    .in_offset_x(drv.ox), .in_offset_y(drv.oy), .in_offset_z(drv.oz),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_m00(got.m00), .out_m01(got.m01), .out_m02(got.m02),
    .out_m10(got.m10), .out_m11(got.m11), .out_m12(got.m12),
    .out_m20(got.m20), .out_m21(got.m21), .out_m22(got.m22),
    .out_tx(got.tx), .out_ty(got.ty), .out_tz(got.tz)
  );

  // Pending matrices, oldest first.
  xform_out_t matrix_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  bit stim_done = 0;

  // Round half up (floor of v + half) by s bits.
  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint fxmul(longint a, longint b);
    return rnd_shift(a * b, SCB);
  endfunction

  // CORDIC cosine/sine of an angle in 1/64 degree, SCB fraction bits.
  function automatic void cos_sin(input longint ang, output longint c, output longint s);
    longint a, x, y, z, nx, cc, ss, one;
    longint unsigned ph;
    logic [1:0] quad;
    longint atn[25] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41};
    one = 64'sd1 <<< SCB;
    a = ang % FULL_TURN;
    if (a < 0) a += FULL_TURN;
    ph = ((longint'(a) <<< 32) + FULL_TURN / 2) / FULL_TURN;
    ph &= 64'hFFFF_FFFF;
    quad = ph[31:30];
    z = longint'(ph & 64'h3FFF_FFFF);
    x = GAIN_INV;
    y = 0;
    for (int i = 0; i < SCB + 1 && i < 25; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= atn[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += atn[i];
      end
      x = nx;
    end
    cc = clip(rnd_shift(x, CORDIC_FRAC - SCB), -one, one);
    ss = clip(rnd_shift(y, CORDIC_FRAC - SCB), -one, one);
    case (quad)
      2'd0: begin c = cc;  s = ss;  end
      2'd1: begin c = -ss; s = cc;  end
      2'd2: begin c = -cc; s = -ss; end
      default: begin c = ss; s = -cc; end
    endcase
  endfunction

  function automatic logic signed [24:0] scaled_entry(longint v, longint scl);
    return 25'(clip(rnd_shift(v * scl, SCB - 8), ENT_MIN, ENT_MAX));
  endfunction

  function automatic xform_out_t predict_matrix(xform_in_t t);
    longint cx, sx, cy, sy, cz, sz;
    xform_out_t r;
    cos_sin(t.ax, cx, sx);
    cos_sin(t.ay, cy, sy);
    cos_sin(t.az, cz, sz);
    r.m00 = scaled_entry(fxmul(cy, cz), t.sx);
    r.m01 = scaled_entry(fxmul(fxmul(sx, sy), cz) + fxmul(cx, sz), t.sx);
    r.m02 = scaled_entry(-fxmul(fxmul(cx, sy), cz) + fxmul(sx, sz), t.sx);
    r.m10 = scaled_entry(-fxmul(cy, sz), t.sy);
    r.m11 = scaled_entry(-fxmul(fxmul(sx, sy), sz) + fxmul(cx, cz), t.sy);
    r.m12 = scaled_entry(fxmul(fxmul(cx, sy), sz) + fxmul(sx, cz), t.sy);
    r.m20 = scaled_entry(sy, t.sz);
    r.m21 = scaled_entry(-fxmul(sx, cy), t.sz);
    r.m22 = scaled_entry(fxmul(cx, cy), t.sz);
    r.tx = t.ox;
    r.ty = t.oy;
    r.tz = t.oz;
    return r;
  endfunction

  task automatic report_mismatch(string field, longint exp_v, longint got_v);
    errors++;
    $display("MISMATCH txn %0d %s: expected %0d got %0d", n_checked, field, exp_v, got_v);
  endtask

  // Directed rows. Typed rows, such as the identity at zero angles and unit scales,
  // are read off directly (1.0 = 65536 in Q8.16); other rows use the predictor.
  typedef struct {
    xform_in_t  stim;
    bit         typed;
    xform_out_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic xform_in_t mk(int ax, int ay, int az, int sx, int sy, int sz,
                                   int ox, int oy, int oz);
    xform_in_t t;
    t.ax = 16'(ax); t.ay = 16'(ay); t.az = 16'(az);
    t.sx = 16'(sx); t.sy = 16'(sy); t.sz = 16'(sz);
    t.ox = ox; t.oy = oy; t.oz = oz;
    return t;
  endfunction

  function automatic void add_row(xform_in_t t);
    dir_row_t d;
    d.stim = t; d.typed = 0; d.want = '0;
    dir_rows = {dir_rows, d};
  endfunction

  initial begin
    dir_row_t d;
    // identity: zero angles, unit scale, position passes through
    d.stim = mk(0, 0, 0, 256, 256, 256, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    d.typed = 1;
    d.want = '0;
    d.want.m00 = 65536; d.want.m11 = 65536; d.want.m22 = 65536;
    d.want.tx = 32'h7FFF_FFFF; d.want.ty = 32'h8000_0000; d.want.tz = 0;
    dir_rows = {dir_rows, d};
    // zero scale clears all nine entries
    d.stim = mk(1234, -5678, 32767, 0, 0, 0, -1, 1, 12345);
    d.typed = 1;
    d.want = '0;
    d.want.tx = -1; d.want.ty = 1; d.want.tz = 12345;
    dir_rows = {dir_rows, d};
    // scale extremes: -128.0 and +127.996 on an identity rotation
    d.stim = mk(0, 0, 0, -32768, -32768, -32768, 0, 0, 0);
    d.typed = 1;
    d.want = '0;
    d.want.m00 = -25'sd8388608; d.want.m11 = -25'sd8388608;
    d.want.m22 = -25'sd8388608;
    dir_rows = {dir_rows, d};
    d.stim = mk(0, 0, 0, 32767, 32767, 32767, 0, 0, 0);
    d.want.m00 = 25'(longint'(32767) * 256); d.want.m11 = d.want.m00;
    d.want.m22 = d.want.m00;
    dir_rows = {dir_rows, d};
    // quadrant boundaries, full-turn wrap, field extremes
    add_row(mk(5760, 0, 0, 256, 256, 256, 0, 0, 0));
    add_row(mk(0, 11520, 0, 256, 256, 256, 0, 0, 0));
    add_row(mk(0, 0, 17280, 256, 256, 256, 0, 0, 0));
    add_row(mk(23040, -23040, -5760, 256, 256, 256, 0, 0, 0));
    add_row(mk(-32768, -32768, -32768, -32768, -32768, -32768,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    add_row(mk(32767, 32767, 32767, 32767, 32767, 32767,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    add_row(mk(2880, 2880, 2880, 32767, -32768, 32767, 0, 0, 0));
    add_row(mk(-1, 1, -2880, 256, -256, 512, -65536, 65536, 1));
    add_row(mk(1920, -7680, 9600, 65, -65, 1, 0, 0, 0));
    add_row(mk(-11520, 5760, 17280, -32768, 32767, -32768, 0, 0, 0));
  end

  function automatic xform_in_t rand_item();
    xform_in_t t;
    t = xform_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    // mostly angles inside one turn and moderate scales, some full range
    if ($urandom_range(3) != 0) begin
      t.ax = 16'($signed($urandom_range(46079)) - 23040);
      t.ay = 16'($signed($urandom_range(46079)) - 23040);
      t.az = 16'($signed($urandom_range(46079)) - 23040);
    end
    if ($urandom_range(3) != 0) begin
      t.sx = 16'($signed($urandom_range(2047)) - 1024);
      t.sy = 16'($signed($urandom_range(2047)) - 1024);
      t.sz = 16'($signed($urandom_range(2047)) - 1024);
    end
    return t;
  endfunction

  // Send one transaction: present it at the falling edge, hold until taken.
  task automatic send_txn(xform_in_t t);
    drv <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    matrix_q = {matrix_q, predict_matrix(t)};
    n_sent++;
    @(negedge clk);
  endtask

  // Sender: bursts of random length separated by random gaps.
  initial begin
    int burst, total, gap;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed) begin
        // the table's typed value must agree with the predictor as well
        if (predict_matrix(dir_rows[i].stim) != dir_rows[i].want)
          report_mismatch("directed_row", i, 0);
      end
      send_txn(dir_rows[i].stim);
      gap = ($urandom_range(3) == 0) ? $urandom_range(3) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    total = 0;
    while (total < N_RANDOM) begin
      burst = $urandom_range(40, 1);
      for (int k = 0; k < burst && total < N_RANDOM; k++) begin
        send_txn(rand_item());
        total++;
      end
      gap = ($urandom_range(2) != 0) ? $urandom_range(12) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid <= 1'b0;
    stim_done = 1;
  end

  // Receiver stall pattern: quiet stretches and random stalling, in random order.
  initial begin
    int phase_len;
    @(posedge rst_n);
    forever begin
      phase_len = $urandom_range(60, 10);
      if ($urandom_range(2) == 0) begin
        out_stall <= 1'b0;
        repeat (phase_len) @(negedge clk);
      end else begin
        repeat (phase_len) begin
          out_stall <= ($urandom_range(99) < 45);
          @(negedge clk);
        end
      end
    end
  end

  // Output monitor: compare each accepted transaction with the oldest expectation.
  always @(posedge clk) begin
    xform_out_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (matrix_q.size() == 0) begin
        report_mismatch("unexpected_output", 0, 1);
      end else begin
        e = matrix_q.pop_front();
        if (got.m00 !== e.m00) report_mismatch("m00", e.m00, got.m00);
        if (got.m01 !== e.m01) report_mismatch("m01", e.m01, got.m01);
        if (got.m02 !== e.m02) report_mismatch("m02", e.m02, got.m02);
        if (got.m10 !== e.m10) report_mismatch("m10", e.m10, got.m10);
        if (got.m11 !== e.m11) report_mismatch("m11", e.m11, got.m11);
        if (got.m12 !== e.m12) report_mismatch("m12", e.m12, got.m12);
        if (got.m20 !== e.m20) report_mismatch("m20", e.m20, got.m20);
        if (got.m21 !== e.m21) report_mismatch("m21", e.m21, got.m21);
        if (got.m22 !== e.m22) report_mismatch("m22", e.m22, got.m22);
        if (got.tx !== e.tx) report_mismatch("tx", e.tx, got.tx);
        if (got.ty !== e.ty) report_mismatch("ty", e.ty, got.ty);
        if (got.tz !== e.tz) report_mismatch("tz", e.tz, got.tz);
      end
      n_checked++;
    end
  end

  // Drain, then settle for the pipeline depth and give the verdict.
  initial begin
    wait (stim_done);
    while (matrix_q.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (matrix_q.size() != 0)
      report_mismatch("missing_outputs", 0, matrix_q.size());
    $display("Sent %0d transactions (%0d directed), checked %0d matrices, %0d errors",
             n_sent, dir_rows.size(), n_checked, errors);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Watchdog: far beyond the slowest legitimate run.
  initial begin
    #2_000_000;
    $display("Timeout after %0d transactions checked", n_checked);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
